FILE: design/mssched_pkg.sv
// Package for the process scheduler: slot table entry layout, strategy and
// item kind codes, default slot count. No dependencies.
package mssched_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam int PRI_W  = 8;
  localparam int AGE_W  = 16;
  localparam int RND_W  = 15;
  localparam int ID_W   = 3;

  // strategy register codes
  localparam logic [2:0] STRAT_EVEN   = 3'd0;
  localparam logic [2:0] STRAT_RANDOM = 3'd1;
  localparam logic [2:0] STRAT_RR     = 3'd2;
  localparam logic [2:0] STRAT_AGING  = 3'd3;
  localparam logic [2:0] STRAT_RTC    = 3'd4;

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SCHED = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  typedef struct packed {
    logic             rdy;
    logic [PRI_W-1:0] pri;
    logic [AGE_W-1:0] age;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

FILE: design/mssched_in_if.sv
// Request channel of the process scheduler: valid/ready plus the item fields.
// Stand-alone interface, no dependencies.
interface mssched_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  slot;
  logic        ready_req;
  logic [7:0]  priority_req;
  logic        clear_age;
  logic [2:0]  current;
  logic [14:0] random_value;

  modport source (output valid, kind, slot, ready_req, priority_req, clear_age, current,
                  random_value, input ready);
  modport sink   (input valid, kind, slot, ready_req, priority_req, clear_age, current,
                  random_value, output ready);
endinterface

FILE: design/mssched_out_if.sv
// Result channel of the process scheduler: valid/ready plus the chosen id.
// Stand-alone interface, no dependencies.
interface mssched_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] next_process;

  modport source (output valid, next_process, input ready);
  modport sink   (input valid, next_process, output ready);
endinterface

FILE: design/mssched_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mssched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/multi_strategy_process_scheduler_top.sv
// Process scheduler top level: slot table in one RAM, scan sequencer, picks.
// Depends on mssched_pkg, mssched_in_if, mssched_out_if and mssched_ram.
//
// Each accepted transaction is handled alone. The block sweeps the slot table
// (ready flag, priority, age per slot) through the single read port of its RAM,
// one slot a cycle, writing each entry back as it passes; a schedule request
// then loads its result into the output register. A random-strategy schedule
// request with any ready slot first computes a remainder and walks to the
// chosen ready slot. One result per schedule request, none for slot writes or
// reset transactions; a finished result waits in an output register while the
// next transaction is already accepted. The slot table reads as all zero after
// reset, with no clearing pass. The user must write the strategy register only
// while the block is idle; the block itself does not enforce it.
module multi_strategy_process_scheduler_top #(
  parameter int SLOT_COUNT = mssched_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                strategy_we,
  input  logic [2:0]          strategy_wdata,
  mssched_in_if.sink          in_ch,
  mssched_out_if.source       out_ch
);

  import mssched_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state;
  logic [2:0]        strategy;

  // captured transaction
  logic [1:0]        kind;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_ok;
  logic              ready_req;
  logic [PRI_W-1:0]  priority_req;
  logic              clear_age;
  logic [IDX_W-1:0]  cur_idx;
  logic [RND_W-1:0]  rnd;

  // scan pipeline
  logic [CNT_W-1:0]  rd_cnt;
  logic              p_vld;
  logic [IDX_W-1:0]  p_idx;
  logic [SLOT_COUNT-1:0] written;

  // scan results
  logic              cur_rdy;
  logic [PRI_W-1:0]  cur_pri;
  logic [PRI_W-1:0]  pri0;
  logic              found_above;
  logic [IDX_W-1:0]  above_idx;
  logic [PRI_W-1:0]  above_pri;
  logic              found_any;
  logic [IDX_W-1:0]  any_idx;
  logic [PRI_W-1:0]  any_pri;
  logic [CNT_W-1:0]  rdy_count;
  logic [SLOT_COUNT-1:0] rdy_vec;
  logic [IDX_W-1:0]  best_idx;
  logic [AGE_W-1:0]  best_age;
  logic [PRI_W-1:0]  best_pri;

  // random pick
  logic [3:0]        div_cnt;
  logic [CNT_W-1:0]  rem;
  logic [IDX_W-1:0]  pick_idx;
  logic [CNT_W-1:0]  seen;

  logic [PRI_W-1:0]  time_slice;
  logic [IDX_W-1:0]  res;
  logic              out_valid;
  logic [2:0]        out_np;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t       ent_rd;
  slot_entry_t       ent_wr;
  logic [AGE_W-1:0]  age_c;
  logic [AGE_W-1:0]  new_age;

  logic [IDX_W-1:0]  even_idx;
  logic [PRI_W-1:0]  even_pri;
  logic [CNT_W:0]    rem_sh;
  logic              in_acc;

  mssched_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_idx),
    .wdata (ent_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.next_process = out_np;
  assign ram_raddr           = rd_cnt[IDX_W-1:0];
  assign ram_we              = (state == S_SCAN) && p_vld;

  // mask entries never written to their reset value
  always_comb begin
    ent_rd = written[p_idx] ? slot_entry_t'(ram_rdata) : '0;
  end

  // aging update of the entry in flight
  always_comb begin
    age_c   = (p_idx == cur_idx) ? '0 : ent_rd.age;
    new_age = age_c + ((ent_rd.rdy && (p_idx != '0)) ? AGE_W'(ent_rd.pri) : '0);
  end

  // modify the entry in flight before write-back
  always_comb begin
    ent_wr = ent_rd;
    case (kind)
      KIND_WRITE: begin
        if (slot_ok && (p_idx == slot_idx)) begin
          ent_wr.rdy = ready_req;
          ent_wr.pri = priority_req;
          if (clear_age) begin
            ent_wr.age = '0;
          end
        end
      end
      KIND_SCHED: begin
        if (strategy == STRAT_AGING) begin
          ent_wr.age = new_age;
        end
      end
      KIND_RESET: begin
        if (strategy == STRAT_AGING) begin
          ent_wr.age = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // next ready slot after current, wrapping past slot 0
  always_comb begin
    if (found_above) begin
      even_idx = above_idx;
      even_pri = above_pri;
    end else if (found_any) begin
      even_idx = any_idx;
      even_pri = any_pri;
    end else begin
      even_idx = '0;
      even_pri = pri0;
    end
  end

  assign rem_sh = {rem, rnd[RND_W-1]};

  // strategy register
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= STRAT_EVEN;
    end else if (strategy_we) begin
      strategy <= strategy_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_cnt     <= '0;
      p_vld      <= 1'b0;
      written    <= '0;
      time_slice <= '0;
      out_valid  <= 1'b0;
    end else begin
      // present a finished result, drop it once taken
      if ((state == S_EMIT) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        written[p_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state        <= S_SCAN;
            kind         <= in_ch.kind;
            slot_ok      <= int'(in_ch.slot) < SLOT_COUNT;
            slot_idx     <= IDX_W'(in_ch.slot);
            ready_req    <= in_ch.ready_req;
            priority_req <= in_ch.priority_req;
            clear_age    <= in_ch.clear_age;
            cur_idx      <= (int'(in_ch.current) < SLOT_COUNT) ? IDX_W'(in_ch.current) : '0;
            rnd          <= in_ch.random_value;
            rd_cnt       <= '0;
            p_vld        <= 1'b0;
            found_above  <= 1'b0;
            found_any    <= 1'b0;
            rdy_count    <= '0;
            rdy_vec      <= '0;
          end
        end
        S_SCAN: begin
          // issue reads
          if (rd_cnt < CNT_W'(SLOT_COUNT)) begin
            p_idx  <= rd_cnt[IDX_W-1:0];
            rd_cnt <= rd_cnt + 1'b1;
            p_vld  <= 1'b1;
          end else begin
            p_vld <= 1'b0;
          end
          // gather over the entry in flight
          if (p_vld) begin
            if (p_idx == cur_idx) begin
              cur_rdy <= ent_rd.rdy;
              cur_pri <= ent_rd.pri;
            end
            if ((p_idx != '0) && ent_rd.rdy) begin
              rdy_vec[p_idx] <= 1'b1;
              rdy_count      <= rdy_count + 1'b1;
              if (!found_any) begin
                found_any <= 1'b1;
                any_idx   <= p_idx;
                any_pri   <= ent_rd.pri;
              end
              if ((p_idx > cur_idx) && !found_above) begin
                found_above <= 1'b1;
                above_idx   <= p_idx;
                above_pri   <= ent_rd.pri;
              end
            end
            if (p_idx == '0) begin
              pri0     <= ent_rd.pri;
              best_idx <= '0;
              best_age <= new_age;
              best_pri <= ent_rd.pri;
            end else if (ent_rd.rdy && ((new_age > best_age) ||
                         ((new_age == best_age) && (ent_rd.pri > best_pri)))) begin
              best_idx <= p_idx;
              best_age <= new_age;
              best_pri <= ent_rd.pri;
            end
          end else if (rd_cnt == CNT_W'(SLOT_COUNT)) begin
            // scan drained: decide
            if (kind != KIND_SCHED) begin
              state <= S_IDLE;
            end else if ((strategy == STRAT_RANDOM) && (rdy_count != '0)) begin
              state <= S_MOD;
            end else begin
              state <= S_EMIT;
            end
            if (kind == KIND_RESET) begin
              if (strategy == STRAT_RR) begin
                time_slice <= cur_pri;
              end
            end else if (kind == KIND_SCHED) begin
              case (strategy)
                STRAT_RANDOM: begin
                  if (rdy_count == '0) begin
                    res <= '0;
                  end else begin
                    div_cnt <= 4'(RND_W - 1);
                    rem     <= '0;
                  end
                end
                STRAT_RR: begin
                  if ((time_slice > 8'd1) && cur_rdy) begin
                    time_slice <= time_slice - 1'b1;
                    res        <= cur_idx;
                  end else begin
                    time_slice <= even_pri;
                    res        <= even_idx;
                  end
                end
                STRAT_AGING: res <= best_idx;
                STRAT_RTC:   res <= cur_rdy ? cur_idx : even_idx;
                default:     res <= even_idx;
              endcase
            end
          end
        end
        S_MOD: begin
          // one remainder bit a cycle
          rnd <= {rnd[RND_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, rdy_count}) begin
            rem <= CNT_W'(rem_sh - {1'b0, rdy_count});
          end else begin
            rem <= CNT_W'(rem_sh);
          end
          if (div_cnt == '0) begin
            state    <= S_PICK;
            pick_idx <= IDX_W'(1);
            seen     <= '0;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_PICK: begin
          // walk to the rem-th ready slot
          if (rdy_vec[pick_idx]) begin
            if (seen == rem) begin
              res   <= pick_idx;
              state <= S_EMIT;
            end
            seen <= seen + 1'b1;
          end
          pick_idx <= pick_idx + 1'b1;
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_np <= 3'(res);
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_pvld_in_scan: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> (state == S_SCAN))
    else $error("scan pipeline active outside scan");

  a_rdcnt_range: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CNT_W'(SLOT_COUNT))
    else $error("read counter past table");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && (!out_valid || out_ch.ready)) |=> out_valid)
    else $error("result not presented");

  a_pick_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (rem < rdy_count))
    else $error("random index beyond ready count");

endmodule

FILE: test/multi_strategy_process_scheduler_top_test.sv
// Testbench for the process scheduler: drives slot writes, schedule requests and
// reset transactions, predicts every chosen process id and checks it in order.
// Depends on mssched_pkg, mssched_in_if, mssched_out_if and the scheduler top.
`timescale 1ns / 100ps

module multi_strategy_process_scheduler_top_test;
  import mssched_pkg::*;

  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        ready_req;
    logic [7:0]  priority_req;
    logic        clear_age;
    logic [2:0]  current;
    logic [14:0] random_value;
  } sched_item_t;

  logic clk;
  logic rst;
  logic strategy_we;
  logic [2:0] strategy_wdata;

  mssched_in_if  in_ch ();
  mssched_out_if out_ch ();

  multi_strategy_process_scheduler_top dut (
    .clk(clk),
    .rst(rst),
    .strategy_we(strategy_we),
    .strategy_wdata(strategy_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // shadow copy of the scheduler state
  logic [2:0]       model_strategy;
  logic             model_ready [SLOTS];
  logic [PRI_W-1:0] model_pri [SLOTS];
  logic [AGE_W-1:0] model_age [SLOTS];
  logic [7:0]       model_slice;

  sched_item_t pending_items[$];
  logic [2:0]  expected_ids[$];

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  bit long_hold_req = 0;
  bit long_hold_done = 0;

  function automatic logic [2:0] next_even(logic [2:0] cur);
    int idx;
    idx = cur;
    for (int n = 1; n < SLOTS; n++) begin
      idx = idx + 1;
      if (idx >= SLOTS) idx = 1;
      if (model_ready[idx]) return idx[2:0];
    end
    return 3'd0;
  endfunction

  // advance the shadow state by one transaction; return 1 when a result follows
  function automatic bit predict_next(sched_item_t it, output logic [2:0] nxt);
    int cnt, k, seen, best;
    nxt = 3'd0;
    if (it.kind == KIND_WRITE) begin
      model_ready[it.slot] = it.ready_req;
      model_pri[it.slot] = it.priority_req;
      if (it.clear_age) model_age[it.slot] = '0;
      return 0;
    end
    if (it.kind == KIND_RESET) begin
      if (model_strategy == STRAT_RR) model_slice = model_pri[it.current];
      else if (model_strategy == STRAT_AGING)
        for (int i = 0; i < SLOTS; i++) model_age[i] = '0;
      return 0;
    end
    if (it.kind != KIND_SCHED) return 0;
    case (model_strategy)
      STRAT_RANDOM: begin
        cnt = 0;
        for (int i = 1; i < SLOTS; i++) if (model_ready[i]) cnt++;
        if (cnt != 0) begin
          k = int'(it.random_value) % cnt;
          seen = 0;
          for (int i = 1; i < SLOTS; i++)
            if (model_ready[i]) begin
              if (seen == k) nxt = i[2:0];
              seen++;
            end
        end
      end
      STRAT_RR: begin
        if (model_slice > 1 && model_ready[it.current]) begin
          model_slice = model_slice - 8'd1;
          nxt = it.current;
        end else begin
          nxt = next_even(it.current);
          model_slice = model_pri[nxt];
        end
      end
      STRAT_AGING: begin
        model_age[it.current] = '0;
        for (int i = 1; i < SLOTS; i++)
          if (model_ready[i]) model_age[i] = model_age[i] + AGE_W'(model_pri[i]);
        best = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (!model_ready[i]) continue;
          if (model_age[i] > model_age[best]) best = i;
          else if (model_age[i] == model_age[best] && model_pri[i] > model_pri[best])
            best = i;
        end
        nxt = best[2:0];
      end
      STRAT_RTC: nxt = model_ready[it.current] ? it.current : next_even(it.current);
      default: nxt = next_even(it.current);
    endcase
    return 1;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) items_sent++;
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid && in_ch.ready) void'(pending_items.pop_front());
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid <= 1'b1;
          {in_ch.kind, in_ch.slot, in_ch.ready_req, in_ch.priority_req, in_ch.clear_age,
           in_ch.current, in_ch.random_value} <= pending_items[0];
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // sink: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done && hold_off == 0) begin
      hold_off <= 400;
      long_hold_done <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= (hold_off == 1);
    end else begin
      out_ch.ready <= (items_sent % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    logic [2:0] want;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_ids.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result next_process=%0d",
                                         out_ch.next_process);
        end else begin
          want = expected_ids.pop_front();
          if (out_ch.next_process !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("next_process mismatch: expected %0d, got %0d",
                                           want, out_ch.next_process);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_item(sched_item_t it);
    logic [2:0] nxt;
    if (predict_next(it, nxt)) expected_ids.push_back(nxt);
    pending_items.push_back(it);
  endtask

  task automatic write_slot(int s, bit rdy, int pri, bit clr);
    sched_item_t it;
    it = '0;
    it.kind = KIND_WRITE;
    it.slot = 3'(s);
    it.ready_req = rdy;
    it.priority_req = 8'(pri);
    it.clear_age = clr;
    it.random_value = 15'($urandom_range(0, 32767));
    queue_item(it);
  endtask

  task automatic schedule(logic [1:0] k, int cur, int rnd);
    sched_item_t it;
    it = '0;
    it.kind = k;
    it.current = 3'(cur);
    it.random_value = 15'(rnd);
    it.slot = 3'($urandom_range(0, 7));
    it.priority_req = 8'($urandom_range(0, 255));
    queue_item(it);
  endtask

  // wait for the queue to drain, then let the block settle
  task automatic drain();
    while (pending_items.size() != 0 || expected_ids.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_strategy(logic [2:0] s);
    drain();
    strategy_we <= 1'b1;
    strategy_wdata <= s;
    @(posedge clk);
    strategy_we <= 1'b0;
    model_strategy = s;
  endtask

  function automatic sched_item_t random_item();
    sched_item_t it;
    int r;
    it = sched_item_t'($bits(sched_item_t)'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 35) it.kind = KIND_WRITE;
    else if (r < 90) it.kind = KIND_SCHED;
    else if (r < 97) it.kind = KIND_RESET;
    else it.kind = 2'd3;
    if (it.kind == KIND_WRITE && $urandom_range(0, 3) != 0) it.ready_req = 1'b1;
    if ($urandom_range(0, 4) == 0) it.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else if ($urandom_range(0, 2) == 0) it.priority_req = 8'($urandom_range(0, 4));
    return it;
  endfunction

  initial begin
    logic [2:0] strat_list[];
    strat_list = '{STRAT_EVEN, STRAT_RANDOM, STRAT_RR, STRAT_AGING, STRAT_RTC,
                   3'd7, 3'd5, STRAT_AGING, STRAT_RR, STRAT_RANDOM};
    rst = 1'b1;
    strategy_we = 1'b0;
    strategy_wdata = '0;
    model_strategy = STRAT_EVEN;
    model_slice = '0;
    for (int i = 0; i < SLOTS; i++) begin
      model_ready[i] = 0;
      model_pri[i] = '0;
      model_age[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, idle slot ready, every kind
    schedule(KIND_SCHED, 0, 0);
    schedule(KIND_SCHED, 7, 32767);
    write_slot(0, 1, 255, 1);
    write_slot(7, 1, 255, 0);
    write_slot(3, 1, 0, 1);
    schedule(KIND_SCHED, 7, 0);
    schedule(KIND_SCHED, 3, 32767);
    schedule(KIND_RESET, 0, 0);
    schedule(2'd3, 5, 12345);
    set_strategy(STRAT_RANDOM);
    schedule(KIND_SCHED, 0, 32767);
    schedule(KIND_SCHED, 1, 1);
    set_strategy(STRAT_RR);
    schedule(KIND_RESET, 7, 0);
    schedule(KIND_SCHED, 7, 0);
    schedule(KIND_SCHED, 7, 0);
    write_slot(7, 0, 2, 0);
    schedule(KIND_SCHED, 7, 0);
    set_strategy(STRAT_AGING);
    write_slot(5, 1, 255, 1);
    schedule(KIND_SCHED, 0, 0);
    schedule(KIND_SCHED, 5, 0);
    schedule(KIND_RESET, 0, 0);
    set_strategy(STRAT_RTC);
    schedule(KIND_SCHED, 0, 0);
    schedule(KIND_SCHED, 5, 0);

    // random phases, one per strategy setting
    foreach (strat_list[p]) begin
      set_strategy(strat_list[p]);
      if (p == 2) long_hold_req = 1;
      for (int n = 0; n < 190; n++) queue_item(random_item());
    end
    drain();

    $display("Covered %0d transactions, %0d results, all five strategies and unused codes.",
             items_sent, results_seen);
    if (mismatches == 0 && expected_ids.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mssched_pkg.sv
design/mssched_in_if.sv
design/mssched_out_if.sv
design/mssched_ram.sv
design/multi_strategy_process_scheduler_top.sv
test/multi_strategy_process_scheduler_top_test.sv
